// File: hdl/bpts_pkg.sv
`timescale 1ns / 1ps

package bpts_pkg;

	// Field and register widths
	localparam int TIME_W     = 48;
	localparam int COUNT_W    = 16;
	localparam int TICK_W     = 32;
	localparam int TOTAL_W    = 16;
	localparam int CMD_W      = 2;
	localparam int PHASE_W    = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Derived widths: a mark never wraps at THR_W bits
	localparam int PROD_W = COUNT_W + TICK_W;
	localparam int THR_W  = ((TIME_W > PROD_W) ? TIME_W : PROD_W) + 2;
	localparam int NEXT_W = COUNT_W + 1;
	localparam int CMP_W  = (NEXT_W > TOTAL_W) ? NEXT_W : TOTAL_W;

	// Mark recompute after a register write: multiply stage, then load
	localparam int              CALC_CNT_W  = 2;
	localparam logic [CALC_CNT_W-1:0] CALC_CYCLES = CALC_CNT_W'(2);

	// Commands
	localparam logic [CMD_W-1:0] CMD_START = CMD_W'(1);
	localparam logic [CMD_W-1:0] CMD_ABORT = CMD_W'(2);

	// Reported phase codes
	localparam logic [PHASE_W-1:0] PH_IDLE  = PHASE_W'(0);
	localparam logic [PHASE_W-1:0] PH_DELAY = PHASE_W'(1);
	localparam logic [PHASE_W-1:0] PH_POS   = PHASE_W'(2);
	localparam logic [PHASE_W-1:0] PH_NEG   = PHASE_W'(3);
	localparam logic [PHASE_W-1:0] PH_DONE  = PHASE_W'(4);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DELAY  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_HIGH   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL  = CFG_IDX_W'(3);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DELAY = 5'b00010,
		ST_POS   = 5'b00100,
		ST_NEG   = 5'b01000,
		ST_DONE  = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [TICK_W-1:0]  delay;
		logic [TICK_W-1:0]  period;
		logic [TICK_W-1:0]  high;
		logic [TOTAL_W-1:0] total;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic load;
	} calc_t;

	typedef struct packed {
		logic              latch;
		logic              advance;
		logic              wrap;
		logic [TIME_W-1:0] now;
	} mark_upd_t;

	function automatic logic [PHASE_W-1:0] phase_code(input phase_t st);
		logic [PHASE_W-1:0] code;
		unique case (st)
			ST_IDLE:  code = PH_IDLE;
			ST_DELAY: code = PH_DELAY;
			ST_POS:   code = PH_POS;
			ST_NEG:   code = PH_NEG;
			default:  code = PH_DONE;
		endcase
		return code;
	endfunction

endpackage

// File: hdl/bpts_if.sv
`timescale 1ns / 1ps

interface bpts_in_if import bpts_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [TIME_W-1:0] now_time;

	modport source (output valid, output command, output now_time, input ready);
	modport sink   (input valid, input command, input now_time, output ready);
endinterface

interface bpts_out_if import bpts_pkg::*;;
	logic               valid;
	logic               ready;
	logic [PHASE_W-1:0] phase;

	modport source (output valid, output phase, input ready);
	modport sink   (input valid, input phase, output ready);
endinterface

// File: hdl/bpts_cfg.sv
`timescale 1ns / 1ps

module bpts_cfg import bpts_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  index,
	input  logic [CFG_DATA_W-1:0] data,
	output cfg_t                  cfg,
	output calc_t                 calc
);

	cfg_t                  cfg_q;
	logic [CALC_CNT_W-1:0] calc_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay  <= '0;
			cfg_q.period <= '0;
			cfg_q.high   <= '0;
			cfg_q.total  <= TOTAL_W'(1);
			calc_cnt_q   <= '0;
		end else if (wr_en) begin
			unique case (index)
				REG_DELAY:  cfg_q.delay  <= data[TICK_W-1:0];
				REG_PERIOD: cfg_q.period <= data[TICK_W-1:0];
				REG_HIGH:   cfg_q.high   <= data[TICK_W-1:0];
				REG_TOTAL:  cfg_q.total  <= data[TOTAL_W-1:0];
			endcase
			// restart the mark recompute on every write
			calc_cnt_q <= CALC_CYCLES;
		end else if (calc_cnt_q != '0) begin
			calc_cnt_q <= calc_cnt_q - CALC_CNT_W'(1);
		end
	end

	assign cfg       = cfg_q;
	assign calc.busy = (calc_cnt_q != '0);
	assign calc.load = (calc_cnt_q == CALC_CNT_W'(1));

endmodule

// File: hdl/bpts_marks.sv
`timescale 1ns / 1ps

module bpts_marks import bpts_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  calc_t              calc,
	input  mark_upd_t          upd,
	input  logic [COUNT_W-1:0] count,
	output logic [THR_W-1:0]   delay_mark,
	output logic [THR_W-1:0]   base_mark
);

	logic [TIME_W-1:0] start_q;
	logic [THR_W-1:0]  delay_mark_q;
	logic [THR_W-1:0]  base_mark_q;
	logic [THR_W-1:0]  sd_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [THR_W-1:0]  latch_sum;

	assign latch_sum = THR_W'(upd.now) + THR_W'(cfg.delay);

	// Free-running recompute stage; only used while calc.load is high
	always_ff @(posedge clk) begin
		sd_s1   <= THR_W'(start_q) + THR_W'(cfg.delay);
		prod_s1 <= PROD_W'(count) * PROD_W'(cfg.period);
	end

	// base_mark_q holds start + delay + count * period
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q      <= '0;
			delay_mark_q <= '0;
			base_mark_q  <= '0;
		end else if (calc.load) begin
			delay_mark_q <= sd_s1;
			base_mark_q  <= sd_s1 + THR_W'(prod_s1);
		end else if (upd.latch) begin
			start_q      <= upd.now;
			delay_mark_q <= latch_sum;
			base_mark_q  <= latch_sum;
		end else if (upd.advance) begin
			// a wrapped count starts over at zero periods
			base_mark_q <= upd.wrap ? delay_mark_q : base_mark_q + THR_W'(cfg.period);
		end
	end

	assign delay_mark = delay_mark_q;
	assign base_mark  = base_mark_q;

endmodule

// File: hdl/burst_pulse_train_sequencer_core.sv
`timescale 1ns / 1ps

// Channel  | Dir | Handshake       | Payload
// ---------+-----+-----------------+--------------------------------------
// cmd      | in  | valid / ready   | command (2 bit), now_time (48 bit)
// res      | out | valid / ready   | phase (3 bit)
// cfg      | in  | cfg_wr_en only  | cfg_index (2 bit), cfg_data (32 bit)
//
// One item per clock unless stalled: each accepted item lands with its
// phase in the output register at the accepting edge and is offered
// on res from the next cycle. The phase compare is one wide add and compare
// against a registered mark. A register write drops cmd.ready while the
// marks are rebuilt through the count * period multiplier.
// Reset clears the phase to not started and the marks to zero.
// A stalled res holds its item; cmd.ready follows res.ready the same cycle.

module burst_pulse_train_sequencer_core import bpts_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	bpts_in_if.sink               cmd,
	bpts_out_if.source            res,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t               cfg;
	calc_t              calc;
	mark_upd_t          upd;
	mark_upd_t          upd_go;
	logic [THR_W-1:0]   delay_mark;
	logic [THR_W-1:0]   base_mark;

	phase_t             state_q;
	phase_t             state_d;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_d;
	logic               res_valid_q;
	logic [PHASE_W-1:0] res_phase_q;

	logic               accept;
	logic [THR_W-1:0]   now_ext;
	logic               reach_delay;
	logic               reach_pos;
	logic               reach_neg;
	logic [NEXT_W-1:0]  next_count;
	logic               more_cycles;

	bpts_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg),
		.calc   (calc)
	);

	bpts_marks u_marks (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.calc       (calc),
		.upd        (upd_go),
		.count      (count_q),
		.delay_mark (delay_mark),
		.base_mark  (base_mark)
	);

	// Take an item when no recompute runs and the output slot frees up
	assign cmd.ready = !calc.busy && (!res_valid_q || res.ready);
	assign accept    = cmd.valid && cmd.ready;

	// Phase boundaries: positive ends at base + high, negative at base + period
	assign now_ext     = THR_W'(cmd.now_time);
	assign reach_delay = (now_ext >= delay_mark);
	assign reach_pos   = (now_ext >= base_mark + THR_W'(cfg.high));
	assign reach_neg   = (now_ext >= base_mark + THR_W'(cfg.period));

	// Finish test uses the unwrapped count
	assign next_count  = NEXT_W'(count_q) + NEXT_W'(1);
	assign more_cycles = (CMP_W'(next_count) < CMP_W'(cfg.total));

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		upd.latch   = 1'b0;
		upd.advance = 1'b0;
		upd.wrap    = 1'b0;
		upd.now     = cmd.now_time;
		if (cmd.command == CMD_ABORT) begin
			// abort wins in any phase and re-latches the start time
			state_d   = ST_IDLE;
			count_d   = '0;
			upd.latch = 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.command == CMD_START) begin
						state_d   = ST_DELAY;
						count_d   = '0;
						upd.latch = 1'b1;
					end
				end
				ST_DELAY: begin
					if (reach_delay) begin
						state_d = ST_POS;
						count_d = '0;
					end
				end
				ST_POS: begin
					if (reach_pos) begin
						state_d = ST_NEG;
					end
				end
				ST_NEG: begin
					if (reach_neg) begin
						state_d     = more_cycles ? ST_POS : ST_DONE;
						count_d     = next_count[COUNT_W-1:0];
						upd.advance = 1'b1;
						upd.wrap    = next_count[COUNT_W];
					end
				end
				ST_DONE: begin
					// hold until abort
				end
				default: state_d = ST_DONE;
			endcase
		end
	end

	// Mark updates only for accepted items
	always_comb begin
		upd_go         = upd;
		upd_go.latch   = upd.latch && accept;
		upd_go.advance = upd.advance && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q     <= state_d;
				count_q     <= count_d;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Output payload, held while res stalls
	always_ff @(posedge clk) begin
		if (accept) begin
			res_phase_q <= phase_code(state_d);
		end
	end

	assign res.valid = res_valid_q;
	assign res.phase = res_phase_q;

	// A register write blocks items until the marks are rebuilt
	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> !cmd.ready)
		else $error("item taken during mark recompute");

	// Every accepted item leaves a result behind
	a_item_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res.valid)
		else $error("accepted item gave no result");

	// Abort always reports not started
	a_abort_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd.command == CMD_ABORT)) |=> (res.valid && (res.phase == PH_IDLE)))
		else $error("abort did not report idle");

	// Cycle count stays clear until the pulse phases begin
	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_IDLE) || (state_q == ST_DELAY)) |-> (count_q == '0))
		else $error("cycle count set before pulses began");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

// Testbench for burst_pulse_train_sequencer_core.
// Drives command/timestamp items into the cmd channel and checks the phase on
// the res channel against a cycle-free phase tracker kept in this file. The
// timing registers are loaded only while no item is in flight.
// Directed tests cover reset defaults, the register extremes, thresholds
// beyond the timestamp range, time stepping backwards, start while busy,
// abort, the spare command code and a zero cycle total. A back-pressure test
// stalls the receiver long enough to fill the block. Random rounds run
// start/tick sequences with random content under a range of timing setups.
// Both sides insert random idle cycles per item, with some rounds at full rate.

module tb_top;
	import bpts_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_ROUNDS = 28;
	localparam int ROUND_ITEMS = 64;
	localparam int MARK_W      = TIME_W + TICK_W + 2;

	// Command codes with no name in the package
	localparam logic [CMD_W-1:0] CMD_NONE  = CMD_W'(0);
	localparam logic [CMD_W-1:0] CMD_SPARE = CMD_W'(3);

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bpts_in_if  cmd_if ();
	bpts_out_if res_if ();

	burst_pulse_train_sequencer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_if),
		.res       (res_if),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// Timing setup as last written to the block
	logic [TICK_W-1:0]  tm_delay;
	logic [TICK_W-1:0]  tm_period;
	logic [TICK_W-1:0]  tm_high;
	logic [TOTAL_W-1:0] tm_total;

	// Phase tracker state
	logic [PHASE_W-1:0] trk_phase;
	logic [TIME_W-1:0]  trk_start;
	logic [COUNT_W-1:0] trk_cycles;

	// Phases owed by the block, oldest first
	logic [PHASE_W-1:0] phase_due[$];

	int unsigned items_sent;
	int unsigned results_seen;
	int unsigned phase_errors;
	int unsigned setups_loaded;
	int unsigned cycle_count = 0;
	int unsigned stall_req;
	bit          idle_on;

	// True while now lies below start + delay + mult * period + extra; the sum
	// is formed wide enough that it can never wrap.
	function automatic bit below_mark(input logic [TIME_W-1:0] now,
			input logic [COUNT_W:0] mult, input logic [TICK_W-1:0] extra);
		logic [MARK_W-1:0] mark;
		mark = MARK_W'(trk_start) + MARK_W'(tm_delay)
			+ MARK_W'(mult) * MARK_W'(tm_period) + MARK_W'(extra);
		return MARK_W'(now) < mark;
	endfunction

	// Advance the tracker by one item and return the phase it reports.
	// At most one phase change per item; abort wins over every phase.
	function automatic logic [PHASE_W-1:0] advance_phase(input logic [CMD_W-1:0] code,
			input logic [TIME_W-1:0] now);
		logic [COUNT_W:0] nxt;
		nxt = {1'b0, trk_cycles} + 1'b1;
		if (code == CMD_ABORT) begin
			trk_phase  = PH_IDLE;
			trk_start  = now;
			trk_cycles = '0;
		end else begin
			case (trk_phase)
				PH_IDLE: begin
					// only an idle block takes a start
					if (code == CMD_START) begin
						trk_phase  = PH_DELAY;
						trk_start  = now;
						trk_cycles = '0;
					end
				end
				PH_DELAY: begin
					if (!below_mark(now, '0, '0)) begin
						trk_phase  = PH_POS;
						trk_cycles = '0;
					end
				end
				PH_POS: begin
					if (!below_mark(now, {1'b0, trk_cycles}, tm_high))
						trk_phase = PH_NEG;
				end
				PH_NEG: begin
					// finish test uses the count before it is narrowed
					if (!below_mark(now, nxt, '0)) begin
						trk_phase  = (nxt < {1'b0, tm_total}) ? PH_POS : PH_DONE;
						trk_cycles = nxt[COUNT_W-1:0];
					end
				end
				default: trk_phase = PH_DONE;
			endcase
		end
		return trk_phase;
	endfunction

	function automatic int unsigned draw_gap();
		return idle_on ? $urandom_range(0, 11) : 0;
	endfunction

	// Offer one item and hold it until the block takes it. Call at a rising
	// edge; returns at the edge where the item was accepted, valid still high.
	task automatic send_item(input logic [CMD_W-1:0] code, input logic [TIME_W-1:0] now);
		int unsigned gap;
		gap = draw_gap();
		if (gap != 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_if.valid    <= 1'b1;
		cmd_if.command  <= code;
		cmd_if.now_time <= now;
		@(posedge clk);
		while (!cmd_if.ready) @(posedge clk);
		phase_due.push_back(advance_phase(code, now));
		items_sent++;
	endtask

	// Drop the input, let every owed phase come back, then write all four
	// timing registers on consecutive edges.
	task automatic load_timing(input logic [TICK_W-1:0] dly, input logic [TICK_W-1:0] per,
			input logic [TICK_W-1:0] hi, input logic [TOTAL_W-1:0] total);
		cmd_if.valid <= 1'b0;
		while (phase_due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_DELAY;
		cfg_data  <= dly;
		@(posedge clk);
		cfg_index <= REG_PERIOD;
		cfg_data  <= per;
		@(posedge clk);
		cfg_index <= REG_HIGH;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_index <= REG_TOTAL;
		cfg_data  <= CFG_DATA_W'(total);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tm_delay  = dly;
		tm_period = per;
		tm_high   = hi;
		tm_total  = total;
		setups_loaded++;
	endtask

	// Reset values: zero delay, period and high time, one cycle. Try an idle tick
	// and the spare code, run a whole train to finish, then start while done.
	task automatic check_defaults();
		send_item(CMD_NONE, 48'd5);
		send_item(CMD_SPARE, 48'd6);
		send_item(CMD_START, 48'd10);
		send_item(CMD_NONE, 48'd10);
		send_item(CMD_NONE, 48'd10);
		send_item(CMD_NONE, 48'd10);
		send_item(CMD_START, 48'd11);
		send_item(CMD_NONE, 48'd11);
		send_item(CMD_ABORT, 48'd12);
	endtask

	// All registers at their maximum. A start at the top of the time range
	// puts every mark beyond the timestamp width, so the phase must hold.
	// Then walk the exact boundaries from a start at zero.
	task automatic check_extremes();
		load_timing(TICK_MAX, TICK_MAX, TICK_MAX, {TOTAL_W{1'b1}});
		send_item(CMD_START, TIME_MAX);
		send_item(CMD_NONE, TIME_MAX);
		// time steps backwards below the latched start
		send_item(CMD_NONE, '0);
		// start while busy is ignored
		send_item(CMD_START, '0);
		send_item(CMD_ABORT, '0);
		send_item(CMD_START, '0);
		send_item(CMD_NONE, 48'h0000_FFFF_FFFE);
		send_item(CMD_NONE, 48'h0000_FFFF_FFFF);
		send_item(CMD_NONE, 48'h0001_FFFF_FFFD);
		send_item(CMD_NONE, 48'h0001_FFFF_FFFE);
		send_item(CMD_NONE, 48'h0001_FFFF_FFFE);
		send_item(CMD_ABORT, TIME_MAX);
	endtask

	// A zero cycle total still runs one full cycle before finishing.
	task automatic check_zero_total();
		load_timing('0, '0, '0, '0);
		send_item(CMD_START, 48'd100);
		send_item(CMD_NONE, 48'd100);
		send_item(CMD_NONE, 48'd100);
		send_item(CMD_NONE, 48'd100);
	endtask

	// Hold the receiver off for a long stretch while items keep coming at
	// full rate, so the output register fills and the input stalls.
	task automatic check_backpressure();
		logic [TIME_W-1:0] now;
		load_timing(32'd2, 32'd6, 32'd3, 16'd3);
		idle_on   = 1'b0;
		stall_req = 150;
		now       = 48'd1000;
		send_item(CMD_START, now);
		repeat (39) begin
			now = now + 48'd1;
			send_item(CMD_NONE, now);
		end
		idle_on = 1'b1;
	endtask

	// Random rounds: mostly well-formed start/tick sequences under a fresh
	// timing setup each round, with spare codes, busy starts, aborts, time
	// stepping backwards and random noise mixed in.
	task automatic run_random_rounds();
		logic [TIME_W-1:0] now;
		logic [TIME_W:0]   sum;
		logic [TICK_W-1:0] per;
		logic [TICK_W-1:0] step;
		int unsigned       round_items;
		int unsigned       run_len;
		int unsigned       pick;
		bit                wide;
		for (int r = 0; r < RAND_ROUNDS; r++) begin
			wide = (r % 7) == 3;
			if (wide) begin
				load_timing($urandom, $urandom, $urandom, TOTAL_W'($urandom_range(0, 65535)));
			end else begin
				per = $urandom_range(0, 16);
				load_timing($urandom_range(0, 12), per, $urandom_range(0, per + 3),
					((r % 7) == 5) ? {TOTAL_W{1'b1}} : TOTAL_W'($urandom_range(0, 5)));
			end
			// some rounds run both sides at full rate
			idle_on     = (r % 4) != 1;
			now         = TIME_W'({$urandom, $urandom});
			round_items = 0;
			while (round_items < ROUND_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise: any code, any time
					send_item(CMD_W'($urandom_range(0, 3)), TIME_W'({$urandom, $urandom}));
					round_items++;
				end else begin
					if ($urandom_range(0, 3) == 0) begin
						send_item(CMD_ABORT, now);
						round_items++;
					end
					send_item(CMD_START, now);
					run_len = $urandom_range(4, 30);
					round_items += run_len + 1;
					repeat (run_len) begin
						step = wide ? TICK_W'($urandom) : TICK_W'($urandom_range(0, 6));
						sum  = {1'b0, now} + {{(TIME_W + 1 - TICK_W){1'b0}}, step};
						now  = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
						pick = $urandom_range(0, 99);
						if (pick < 3)
							send_item(CMD_SPARE, now);
						else if (pick < 6)
							send_item(CMD_START, now);
						else if (pick < 8)
							send_item(CMD_ABORT, now);
						else if (pick < 11)
							send_item(CMD_NONE, (now > 48'd20) ?
								now - TIME_W'($urandom_range(1, 20)) : '0);
						else
							send_item(CMD_NONE, now);
					end
				end
			end
		end
	endtask

	// Receiver: draw a stall per item, take each result and compare it with
	// the oldest owed phase.
	initial begin : take_results
		int unsigned        gap;
		logic [PHASE_W-1:0] want;
		res_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap();
			if (stall_req != 0) begin
				gap       = stall_req;
				stall_req = 0;
			end
			if (gap != 0) begin
				res_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			@(posedge clk);
			while (!res_if.valid) @(posedge clk);
			results_seen++;
			if (phase_due.size() == 0) begin
				phase_errors++;
				$display("%0t: phase expected none actual %0d", $time, res_if.phase);
			end else begin
				want = phase_due.pop_front();
				if (res_if.phase !== want) begin
					phase_errors++;
					$display("%0t: phase expected %0d actual %0d", $time, want,
						res_if.phase);
				end
			end
		end
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d phases still owed", cycle_count,
			phase_due.size());
		$display("burst_pulse_train_sequencer_core: mismatch");
		$finish;
	end

	initial begin : run_tests
		arst_n          = 1'b0;
		cmd_if.valid    = 1'b0;
		cmd_if.command  = CMD_NONE;
		cmd_if.now_time = '0;
		cfg_wr_en       = 1'b0;
		cfg_index       = REG_DELAY;
		cfg_data        = '0;
		items_sent      = 0;
		results_seen    = 0;
		phase_errors    = 0;
		setups_loaded   = 0;
		stall_req       = 0;
		idle_on         = 1'b1;
		// tracker starts from the reset state of the block
		tm_delay   = '0;
		tm_period  = '0;
		tm_high    = '0;
		tm_total   = TOTAL_W'(1);
		trk_phase  = PH_IDLE;
		trk_start  = '0;
		trk_cycles = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_defaults();
		check_extremes();
		check_zero_total();
		check_backpressure();
		run_random_rounds();

		// drop the input, drain, then watch for stray results
		cmd_if.valid <= 1'b0;
		while (phase_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d command items under %0d timing setups plus reset defaults;",
			items_sent, setups_loaded);
		$display("compared %0d phase results, %0d wrong.", results_seen, phase_errors);
		if (phase_errors == 0)
			$display("burst_pulse_train_sequencer_core: match");
		else
			$display("burst_pulse_train_sequencer_core: mismatch");
		$finish;
	end

endmodule

// File: sim.f
hdl/bpts_pkg.sv
hdl/bpts_if.sv
hdl/bpts_cfg.sv
hdl/bpts_marks.sv
hdl/burst_pulse_train_sequencer_core.sv
sim/tb_top.sv
